// File: rtl/tkst_pkg.sv
// Shared widths, defaults and beat types for the top-k score tracker.
package tkst_pkg;

	localparam int SCORE_W        = 32;
	localparam int INDEX_BITS     = 16;
	localparam int RANK_W         = 6;
	localparam int KEEP_DEPTH_DEF = 20;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               end_of_set;
	} item_t;

	typedef struct packed {
		logic [RANK_W-1:0]     rank;
		logic [SCORE_W-1:0]    kept_score;
		logic [INDEX_BITS-1:0] entry_index;
		logic                  slot_filled;
		logic                  last_of_run;
	} result_t;

endpackage

// File: rtl/top_k_score_tracker_unit.sv
// Top-k score tracker: keeps the highest scores of a gallery scan, dumps them in rank order.
//
// Usage:
//   item channel (item_valid / item_stall / item): one beat per gallery entry,
//     carrying its score and an end_of_set flag on the final entry of a query.
//     The block numbers entries itself from zero; the count saturates.
//   result channel (result_valid / result_stall / result): after an end_of_set
//     beat, KEEP_DEPTH beats follow in rank order, rank 0 = highest score,
//     last_of_run set on rank KEEP_DEPTH-1.
// Throughput: one item beat per cycle. The insert compares the new score
//   against every rank in parallel and shifts the store in the same cycle.
//   An end_of_set beat copies the store into a dump buffer and clears the
//   store, so the next query streams in while the dump drains.
//   A second end_of_set is held in the input register until the dump buffer
//   is empty, that is until all KEEP_DEPTH of its result beats have moved to the output register.
// Result path: an accepted end_of_set beat goes through the dump buffer, then the output
//   register, to result_valid; later ranks follow one per cycle while result_stall is low.
// Reset: store, arrival count and all handshake state clear; no results pending.
// Stall: result_stall holds the output register; the dump buffer waits, and
//   item beats keep flowing until another end_of_set has to wait.
module top_k_score_tracker_unit #(
	parameter int KEEP_DEPTH = tkst_pkg::KEEP_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tkst_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output tkst_pkg::result_t result
);

	localparam int SW = tkst_pkg::SCORE_W;
	localparam int IW = tkst_pkg::INDEX_BITS;
	localparam int RW = tkst_pkg::RANK_W;

	// input register
	logic            valid_s1;
	tkst_pkg::item_t item_s1;
	logic            s1_go;

	// live store, descending
	logic [SW-1:0] score_q [KEEP_DEPTH];
	logic [IW-1:0] index_q [KEEP_DEPTH];
	logic          filled_q [KEEP_DEPTH];
	logic [IW-1:0] count_q;

	// store after inserting the s1 score
	logic [SW-1:0] ins_score [KEEP_DEPTH];
	logic [IW-1:0] ins_index [KEEP_DEPTH];
	logic          ins_filled [KEEP_DEPTH];
	logic [KEEP_DEPTH-1:0] gt;

	// dump buffer, drained from entry 0
	logic [SW-1:0] dump_score_q [KEEP_DEPTH];
	logic [IW-1:0] dump_index_q [KEEP_DEPTH];
	logic          dump_filled_q [KEEP_DEPTH];
	logic          dump_busy_q;
	logic [RW-1:0] dump_rank_q;
	logic          dump_last;

	logic              out_valid_q;
	tkst_pkg::result_t out_q;
	logic              out_load;

	// end_of_set waits while a previous dump is still draining
	assign s1_go      = valid_s1 && (!item_s1.end_of_set || !dump_busy_q);
	assign item_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_go) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Store is kept descending, so gt is a run of zeros then ones; the new
	// score lands at the first one, after any equal scores.
	always_comb begin
		for (int j = 0; j < KEEP_DEPTH; j++) begin
			gt[j] = item_s1.score > score_q[j];
		end
		for (int j = 0; j < KEEP_DEPTH; j++) begin
			ins_score[j]  = score_q[j];
			ins_index[j]  = index_q[j];
			ins_filled[j] = filled_q[j];
			if (j > 0 && gt[j-1]) begin
				ins_score[j]  = score_q[j-1];
				ins_index[j]  = index_q[j-1];
				ins_filled[j] = filled_q[j-1];
			end else if (gt[j]) begin
				ins_score[j]  = item_s1.score;
				ins_index[j]  = count_q;
				ins_filled[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < KEEP_DEPTH; j++) begin
				score_q[j]  <= '0;
				index_q[j]  <= '0;
				filled_q[j] <= 1'b0;
			end
			count_q <= '0;
		end else if (s1_go) begin
			if (item_s1.end_of_set) begin
				for (int j = 0; j < KEEP_DEPTH; j++) begin
					score_q[j]  <= '0;
					index_q[j]  <= '0;
					filled_q[j] <= 1'b0;
				end
				count_q <= '0;
			end else begin
				for (int j = 0; j < KEEP_DEPTH; j++) begin
					score_q[j]  <= ins_score[j];
					index_q[j]  <= ins_index[j];
					filled_q[j] <= ins_filled[j];
				end
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// output register pulls from the dump head whenever it is free
	assign out_load  = dump_busy_q && (!out_valid_q || !result_stall);
	assign dump_last = dump_rank_q == RW'(KEEP_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_busy_q <= 1'b0;
			dump_rank_q <= '0;
		end else if (s1_go && item_s1.end_of_set) begin
			dump_busy_q <= 1'b1;
			dump_rank_q <= '0;
		end else if (out_load) begin
			dump_rank_q <= dump_rank_q + 1'b1;
			if (dump_last) begin
				dump_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.end_of_set) begin
			for (int j = 0; j < KEEP_DEPTH; j++) begin
				dump_score_q[j]  <= ins_score[j];
				dump_index_q[j]  <= ins_index[j];
				dump_filled_q[j] <= ins_filled[j];
			end
		end else if (out_load) begin
			for (int j = 0; j < KEEP_DEPTH - 1; j++) begin
				dump_score_q[j]  <= dump_score_q[j+1];
				dump_index_q[j]  <= dump_index_q[j+1];
				dump_filled_q[j] <= dump_filled_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !result_stall) begin
			out_valid_q <= dump_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.rank        <= dump_rank_q;
			out_q.kept_score  <= dump_score_q[0];
			out_q.entry_index <= dump_index_q[0];
			out_q.slot_filled <= dump_filled_q[0];
			out_q.last_of_run <= dump_last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: verif/top_k_score_tracker_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the top-k score tracker: watches both channels, predicts each dump, compares beats.
module top_k_score_tracker_unit_checker #(
	parameter int KEEP_DEPTH = tkst_pkg::KEEP_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  tkst_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  tkst_pkg::result_t result,
	output int                fail_count,
	output int                pending
);

	localparam int SW = tkst_pkg::SCORE_W;
	localparam int IW = tkst_pkg::INDEX_BITS;
	localparam int RW = tkst_pkg::RANK_W;

	logic [SW-1:0]     best_score  [KEEP_DEPTH];
	logic [IW-1:0]     best_index  [KEEP_DEPTH];
	logic              best_filled [KEEP_DEPTH];
	logic [IW-1:0]     arrival_index;
	tkst_pkg::result_t ranked_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic clear_ranking();
		for (int r = 0; r < KEEP_DEPTH; r++) begin
			best_score[r]  = '0;
			best_index[r]  = '0;
			best_filled[r] = 1'b0;
		end
		arrival_index = '0;
	endtask

	// Insert one gallery entry; on end_of_set queue the whole ranking as dump beats.
	task automatic rank_entry(input tkst_pkg::item_t it);
		int                slot;
		tkst_pkg::result_t beat;
		slot = KEEP_DEPTH;
		for (int r = KEEP_DEPTH - 1; r >= 0; r--)
			if (it.score > best_score[r]) slot = r;
		if (slot < KEEP_DEPTH) begin
			for (int r = KEEP_DEPTH - 1; r > slot; r--) begin
				best_score[r]  = best_score[r-1];
				best_index[r]  = best_index[r-1];
				best_filled[r] = best_filled[r-1];
			end
			best_score[slot]  = it.score;
			best_index[slot]  = arrival_index;
			best_filled[slot] = 1'b1;
		end
		if (arrival_index != '1) arrival_index = arrival_index + 1'b1;
		if (it.end_of_set) begin
			for (int r = 0; r < KEEP_DEPTH; r++) begin
				beat.rank        = RW'(r);
				beat.kept_score  = best_score[r];
				beat.entry_index = best_index[r];
				beat.slot_filled = best_filled[r];
				beat.last_of_run = (r == KEEP_DEPTH - 1);
				ranked_q = {ranked_q, beat};
			end
			clear_ranking();
		end
	endtask

	task automatic report_mismatch(input string what, input tkst_pkg::result_t want,
		input tkst_pkg::result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s: expected rank %0d score %h index %0d filled %0b last %0b,",
				$time, what, want.rank, want.kept_score, want.entry_index,
				want.slot_filled, want.last_of_run);
			$display("    got rank %0d score %h index %0d filled %0b last %0b",
				got.rank, got.kept_score, got.entry_index, got.slot_filled,
				got.last_of_run);
		end
	endtask

	task automatic check_beat(input tkst_pkg::result_t got);
		tkst_pkg::result_t want;
		if (ranked_q.size() == 0) begin
			report_mismatch("result beat with no dump pending", '0, got);
			return;
		end
		want = ranked_q.pop_front();
		if (got.rank !== want.rank || got.kept_score !== want.kept_score ||
		    got.entry_index !== want.entry_index || got.slot_filled !== want.slot_filled ||
		    got.last_of_run !== want.last_of_run)
			report_mismatch("result mismatch", want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_ranking();
			ranked_q.delete();
			pending = 0;
		end else begin
			if (result_valid && !result_stall) check_beat(result);
			if (item_valid && !item_stall) rank_entry(item);
			pending = ranked_q.size();
		end
	end

endmodule

// File: verif/top_k_score_tracker_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the top-k score tracker: drives gallery scans and gives the verdict.
module top_k_score_tracker_unit_test;

	localparam int KEEP_DEPTH   = tkst_pkg::KEEP_DEPTH_DEF;
	localparam int SW           = tkst_pkg::SCORE_W;
	localparam int RANDOM_ITEMS = 200;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	tkst_pkg::item_t   item;
	logic              result_valid;
	logic              result_stall;
	tkst_pkg::result_t result;
	logic              calm;       // while set, neither side idles
	int                fail_count;
	int                pending;

	top_k_score_tracker_unit #(.KEEP_DEPTH(KEEP_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	top_k_score_tracker_unit_checker #(.KEEP_DEPTH(KEEP_DEPTH)) rank_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Result side: stall on about 29 percent of cycles, never while calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= !calm && ($urandom_range(0, 99) < 29);
		end
	end

	// Score mix: zeros, all-ones, small values so ties are common, full-range values.
	function automatic logic [SW-1:0] pick_score();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return SW'($urandom_range(0, 15));
			default: return SW'($urandom());
		endcase
	endfunction

	// One item beat. Random idle gaps before raising valid; payload holds while stalled.
	task automatic send_item(input logic [SW-1:0] s, input logic eos);
		if (!calm) begin
			while ($urandom_range(0, 99) < 29) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item       <= '{score: s, end_of_set: eos};
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// One gallery scan of len entries; the last carries end_of_set.
	task automatic play_scan(input int len);
		for (int n = 0; n < len; n++) send_item(pick_score(), n == len - 1);
	endtask

	initial begin
		int sent;
		int len;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		calm         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, zero score, ties with a kept score, a short scan that
		// leaves ranks unfilled, a scan of only a zero, then a rising scan that
		// pushes every kept entry down on each beat.
		send_item('1, 1'b0);
		send_item('0, 1'b0);                // never kept, still takes an index
		send_item(SW'(5), 1'b0);
		send_item(SW'(5), 1'b0);            // equal score lands below the first
		send_item('1, 1'b0);                // ties the top score
		send_item(SW'(32'h8000_0000), 1'b1);
		send_item('0, 1'b1);                // nothing kept at all
		for (int n = 0; n < 18; n++)
			send_item(SW'((n + 1) * 32'h0100_0000 + n), n == 17);

		// Random scans of mixed length, some shorter than the store, some long
		// enough to drop entries off the bottom. A stretch in the middle runs calm.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm <= (sent >= 80 && sent < 160);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
			play_scan(len);
			sent += len;
		end
		calm       <= 1'b0;
		item_valid <= 1'b0;

		// Drain: the dump starts only after the last end_of_set beat has been accepted.
		repeat (8) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/tkst_pkg.sv
rtl/top_k_score_tracker_unit.sv
verif/top_k_score_tracker_unit_checker.sv
verif/top_k_score_tracker_unit_test.sv
